[rtl/tcs_pkg.sv]
// Shared types and constants of the timed command sequencer.
package tcs_pkg;

	localparam int unsigned DEF_TABLE_DEPTH = 32;
	localparam int unsigned DEF_TIME_BITS = 24;

	// Most commands one tick may fire.
	localparam int unsigned MAX_FIRE = 32;

	localparam logic signed [15:0] DEFAULT_MOVE_MS = 16'sd1000;
	localparam logic [16:0] PROGRESS_ONE = 17'h10000;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_LOAD = 2'd1,
		OP_START = 2'd2,
		OP_STOP = 2'd3
	} op_t;

	localparam logic [3:0] ACT_NONE = 4'd0;
	localparam logic [3:0] ACT_NECK_ROTATE = 4'd2;
	localparam logic [3:0] ACT_NECK_FWD = 4'd3;
	localparam logic [3:0] ACT_LAST_CODE = 4'd10;

	typedef struct packed {
		op_t operation;
		logic [15:0] advance_ms;
		logic [4:0] entry_index;
		logic [23:0] entry_time;
		logic [3:0] entry_action;
		logic signed [15:0] entry_first_param;
		logic signed [15:0] entry_second_param;
		logic [5:0] step_count;
	} in_t;

	typedef struct packed {
		logic [3:0] action;
		logic signed [15:0] first_param;
		logic signed [15:0] second_param;
		logic [4:0] fired_index;
		logic last;
		logic playing;
		logic [16:0] progress;
	} out_t;

endpackage

[rtl/tcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/timed_command_sequencer.sv]
// Timed command sequencer: a table of timestamped commands played back on tick beats.
//
// A load beat writes one table entry; a start beat arms playback of the first step_count
// entries; each tick beat while playing advances the elapsed time and emits the due commands,
// at most MAX_FIRE of them, one result per cycle while the receiver takes them, and a stop
// beat ends playback. Every input beat yields at least one result; the last result of a beat
// has last set. The table lives in a RAM with one write and one registered read port, and all
// scans go through that read port. Each command fired is first scanned and later emitted, and
// a progress value strictly between zero and one comes from a bit-serial restoring divider
// that produces one quotient bit per cycle. The block takes a new beat only when it is back
// in its idle state; a finished result may still wait in the output register at that time.
module timed_command_sequencer
	import tcs_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_t out_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned EW = TIME_BITS + 36;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_TOT_W = 8'b0000_0010,
		ST_TOT = 8'b0000_0100,
		ST_SCAN_W = 8'b0000_1000,
		ST_SCAN = 8'b0001_0000,
		ST_PROG = 8'b0010_0000,
		ST_DIV = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] active_q;
	logic [PW-1:0] next_entry_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TIME_BITS-1:0] total_q;
	logic running_q;
	logic [5:0] n_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [3:0] div_cnt_q;
	logic [16:0] prog_q;
	logic out_valid_q;
	out_t out_q;

	// Table port signals and entry fields.
	logic wr_en;
	logic [EW-1:0] wr_data;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_data;
	logic [TIME_BITS-1:0] ent_time;
	logic [3:0] ent_act;
	logic signed [15:0] ent_p1;
	logic signed [15:0] ent_p2;

	logic [TIME_BITS-1:0] ld_time;
	logic [3:0] ld_act;
	logic signed [15:0] ld_p2;
	logic [PW-1:0] start_cnt;
	logic [TIME_BITS:0] tick_sum;
	logic [TIME_BITS-1:0] tick_elapsed;
	logic scan_hit;
	logic out_free;
	logic rd_adv;
	logic [PW-1:0] rd_ptr;
	logic [PW-1:0] ptr_inc;
	logic [TIME_BITS:0] rem_shift;
	logic [TIME_BITS:0] rem_diff;
	logic div_ge;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_free = !out_valid_q || out_ready;

	// Load path: saturate the time, drop unknown actions, and apply the default move time
	// to neck moves whose duration is not positive.
	always_comb begin
		ld_time = (32'(in_data.entry_time) > 32'(TIME_MAX)) ? TIME_MAX
			: TIME_BITS'(in_data.entry_time);
		ld_act = (in_data.entry_action > ACT_LAST_CODE) ? ACT_NONE : in_data.entry_action;
		ld_p2 = in_data.entry_second_param;
		if ((ld_act == ACT_NECK_ROTATE || ld_act == ACT_NECK_FWD) && (ld_p2 <= 16'sd0)) begin
			ld_p2 = DEFAULT_MOVE_MS;
		end
	end

	assign wr_en = (state_q == ST_IDLE) && in_valid && (in_data.operation == OP_LOAD)
		&& (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
	assign wr_data = {ld_time, ld_act, in_data.entry_first_param, ld_p2};

	assign ent_time = rd_data[EW-1 -: TIME_BITS];
	assign ent_act = rd_data[35:32];
	assign ent_p1 = rd_data[31:16];
	assign ent_p2 = rd_data[15:0];

	assign start_cnt = (32'(in_data.step_count) > 32'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH)
		: PW'(in_data.step_count);

	assign tick_sum = {1'b0, elapsed_q} + (TIME_BITS + 1)'(in_data.advance_ms);
	assign tick_elapsed = tick_sum[TIME_BITS] ? TIME_MAX : tick_sum[TIME_BITS-1:0];

	assign scan_hit = (ptr_q < active_q) && (n_q < 6'(MAX_FIRE)) && (ent_time <= elapsed_q);

	// The read address runs one entry ahead whenever the pointer steps, so the registered
	// read data always belongs to ptr_q.
	assign rd_adv = ((state_q == ST_SCAN) && scan_hit)
		|| ((state_q == ST_EMIT) && out_free && (n_q != 6'd0));
	assign ptr_inc = PW'(ptr_q + PW'(1));
	assign rd_ptr = rd_adv ? ptr_inc : ptr_q;
	assign rd_addr = rd_ptr[AW-1:0];

	// One step of the restoring divider.
	assign rem_shift = {rem_q, 1'b0};
	assign rem_diff = rem_shift - {1'b0, total_q};
	assign div_ge = (rem_shift >= {1'b0, total_q});

	tcs_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(AW'(in_data.entry_index)),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q <= '0;
			active_q <= '0;
			next_entry_q <= '0;
			elapsed_q <= '0;
			total_q <= '0;
			running_q <= 1'b0;
			n_q <= '0;
			rem_q <= '0;
			div_cnt_q <= '0;
			prog_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q <= '0;
						unique case (in_data.operation)
							OP_TICK: begin
								if (running_q) begin
									elapsed_q <= tick_elapsed;
									ptr_q <= next_entry_q;
									state_q <= ST_SCAN_W;
								end else begin
									state_q <= ST_PROG;
								end
							end
							OP_LOAD: begin
								state_q <= ST_PROG;
							end
							OP_START: begin
								active_q <= start_cnt;
								next_entry_q <= '0;
								elapsed_q <= '0;
								running_q <= 1'b1;
								if (start_cnt == '0) begin
									total_q <= '0;
									state_q <= ST_PROG;
								end else begin
									ptr_q <= PW'(start_cnt - PW'(1));
									state_q <= ST_TOT_W;
								end
							end
							OP_STOP: begin
								running_q <= 1'b0;
								active_q <= '0;
								next_entry_q <= '0;
								total_q <= '0;
								state_q <= ST_PROG;
							end
							default: begin
								state_q <= ST_PROG;
							end
						endcase
					end
				end
				ST_TOT_W: begin
					state_q <= ST_TOT;
				end
				ST_TOT: begin
					total_q <= ent_time;
					state_q <= ST_PROG;
				end
				ST_SCAN_W: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_hit) begin
						ptr_q <= ptr_inc;
						n_q <= n_q + 6'd1;
					end else begin
						// Count how many fire, then rewind to emit them.
						running_q <= (ptr_q < active_q);
						ptr_q <= next_entry_q;
						state_q <= ST_PROG;
					end
				end
				ST_PROG: begin
					if (!running_q || total_q == '0) begin
						prog_q <= '0;
						state_q <= ST_EMIT;
					end else if (elapsed_q >= total_q) begin
						prog_q <= PROGRESS_ONE;
						state_q <= ST_EMIT;
					end else begin
						rem_q <= elapsed_q;
						prog_q <= '0;
						div_cnt_q <= 4'd15;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= div_ge ? rem_diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
					prog_q <= {prog_q[15:0], div_ge};
					if (div_cnt_q == 4'd0) begin
						state_q <= ST_EMIT;
					end else begin
						div_cnt_q <= div_cnt_q - 4'd1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (n_q == 6'd0) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= ptr_inc;
							next_entry_q <= PW'(next_entry_q + PW'(1));
							n_q <= n_q - 6'd1;
							if (n_q == 6'd1) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload; a beat that fires nothing yields one empty command.
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_q.last <= (n_q <= 6'd1);
			out_q.playing <= running_q;
			out_q.progress <= prog_q;
			if (n_q == 6'd0) begin
				out_q.action <= ACT_NONE;
				out_q.first_param <= '0;
				out_q.second_param <= '0;
				out_q.fired_index <= '0;
			end else begin
				out_q.action <= ent_act;
				out_q.first_param <= ent_p1;
				out_q.second_param <= ent_p2;
				out_q.fired_index <= 5'(ptr_q);
			end
		end
	end

	// A beat is taken only from idle, so two accepts never come back to back.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input beat accepted while the previous one is in work");

	a_next_within_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (next_entry_q <= active_q))
		else $error("playback index passed the number of active entries");

	a_active_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(active_q) <= 32'(TABLE_DEPTH))
		else $error("active entry count exceeds the table depth");

	a_fire_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (n_q <= 6'(MAX_FIRE)))
		else $error("more commands pending than one tick may fire");

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the timed command sequencer with its own playback predictor.
`timescale 1ns / 1ps

module tb_top;
	import tcs_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;
	localparam int RANDOM_ITEMS = 130;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 150;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	timed_command_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Predictor copy of the sequencer state.
	logic [23:0] slot_time [DEPTH];
	logic [3:0] slot_act [DEPTH];
	logic signed [15:0] slot_p1 [DEPTH];
	logic signed [15:0] slot_p2 [DEPTH];
	logic [5:0] n_active;
	logic [5:0] next_idx;
	logic [23:0] elapsed_ms;
	logic [23:0] total_ms;
	bit playing_q;

	out_t expected_cmds [$];
	int errors;
	int items_sent;
	int cycles;
	bit idle_on;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timed_command_sequencer: mismatch");
			$finish;
		end
	end

	// Receiver side: random stall bursts while idling is enabled.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string fname, input logic [16:0] e, input logic [16:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, fname, e, a);
		end
	endtask

	always @(posedge clk) begin : result_monitor
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_cmds.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat, expected none actual %h", $time, out_data);
			end else begin
				want = expected_cmds.pop_front();
				check_field("action", want.action, out_data.action);
				check_field("first_param", $unsigned(want.first_param),
					$unsigned(out_data.first_param));
				check_field("second_param", $unsigned(want.second_param),
					$unsigned(out_data.second_param));
				check_field("fired_index", want.fired_index, out_data.fired_index);
				check_field("last", want.last, out_data.last);
				check_field("playing", want.playing, out_data.playing);
				check_field("progress", want.progress, out_data.progress);
			end
		end
	end

	task automatic predict_commands(input in_t it);
		out_t res [$];
		out_t r;
		logic [24:0] sum;
		logic [5:0] cnt;
		logic [39:0] quot;
		logic [16:0] prog;
		logic signed [15:0] p2;
		case (it.operation)
		OP_LOAD: begin
			if (it.entry_index < DEPTH) begin
				slot_time[it.entry_index] = it.entry_time;
				slot_act[it.entry_index] = (it.entry_action > ACT_LAST_CODE) ? ACT_NONE
					: it.entry_action;
				slot_p1[it.entry_index] = it.entry_first_param;
				slot_p2[it.entry_index] = it.entry_second_param;
			end
		end
		OP_START: begin
			cnt = (it.step_count > DEPTH) ? 6'(DEPTH) : it.step_count;
			n_active = cnt;
			next_idx = '0;
			elapsed_ms = '0;
			playing_q = 1'b1;
			total_ms = (cnt != 0) ? slot_time[cnt - 1] : '0;
		end
		OP_STOP: begin
			playing_q = 1'b0;
			n_active = '0;
			next_idx = '0;
			total_ms = '0;
		end
		OP_TICK: begin
			if (playing_q) begin
				sum = {1'b0, elapsed_ms} + it.advance_ms;
				elapsed_ms = sum[24] ? '1 : sum[23:0];
				while (res.size() < MAX_FIRE && next_idx < n_active && next_idx < DEPTH
						&& slot_time[next_idx] <= elapsed_ms) begin
					p2 = slot_p2[next_idx];
					if ((slot_act[next_idx] == ACT_NECK_ROTATE
							|| slot_act[next_idx] == ACT_NECK_FWD) && p2 <= 0)
						p2 = DEFAULT_MOVE_MS;
					r = '0;
					r.action = slot_act[next_idx];
					r.first_param = slot_p1[next_idx];
					r.second_param = p2;
					r.fired_index = next_idx[4:0];
					res.push_back(r);
					next_idx++;
				end
				if (next_idx >= n_active)
					playing_q = 1'b0;
			end
		end
		endcase
		if (res.size() == 0)
			res.push_back('0);
		if (!playing_q || total_ms == 0) begin
			prog = '0;
		end else if (elapsed_ms >= total_ms) begin
			prog = PROGRESS_ONE;
		end else begin
			quot = {elapsed_ms, 16'h0} / {16'h0, total_ms};
			prog = quot[16:0];
		end
		foreach (res[k]) begin
			res[k].last = (k == res.size() - 1);
			res[k].playing = playing_q;
			res[k].progress = prog;
			expected_cmds.push_back(res[k]);
		end
	endtask

	// Called at a rising edge; returns at the edge where the beat is accepted.
	task automatic send_item(input in_t it);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_commands(it);
		items_sent++;
	endtask

	function automatic in_t random_item();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[$bits(in_t)-1:0];
	endfunction

	function automatic logic signed [15:0] rand_param();
		return ($urandom_range(0, 7) == 0) ? 16'sd0 : 16'($urandom());
	endfunction

	function automatic in_t make_load(input int idx, input int t, input int act,
			input logic signed [15:0] p1, input logic signed [15:0] p2);
		in_t it;
		it = random_item();
		it.operation = OP_LOAD;
		it.entry_index = idx[4:0];
		it.entry_time = t[23:0];
		it.entry_action = act[3:0];
		it.entry_first_param = p1;
		it.entry_second_param = p2;
		return it;
	endfunction

	function automatic in_t make_tick(input int adv);
		in_t it;
		it = random_item();
		it.operation = OP_TICK;
		it.advance_ms = adv[15:0];
		return it;
	endfunction

	function automatic in_t make_start(input int cnt);
		in_t it;
		it = random_item();
		it.operation = OP_START;
		it.step_count = cnt[5:0];
		return it;
	endfunction

	function automatic in_t make_stop();
		in_t it;
		it = random_item();
		it.operation = OP_STOP;
		return it;
	endfunction

	function automatic in_t random_load(input int idx, input int t);
		return make_load(idx, t, $urandom_range(0, 15), rand_param(), rand_param());
	endfunction

	function automatic int random_advance();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(0, 65535);
		return $urandom_range(1, 300);
	endfunction

	task automatic test_directed();
		idle_on = 1'b1;
		send_item(make_load(0, 0, 1, 16'sh7fff, -16'sh8000));
		send_item(make_load(1, 0, ACT_NECK_ROTATE, -16'sh8000, 16'sd0));
		send_item(make_load(2, 5, ACT_NECK_FWD, 16'sd0, -16'sd1));
		send_item(make_load(3, 5, ACT_NECK_ROTATE, 16'sd45, 16'sd1));
		// Action codes above the last one are stored as a none command.
		send_item(make_load(4, 100, 13, 16'sd7, 16'sd9));
		send_item(make_load(5, 100, ACT_LAST_CODE, 16'sd1, -16'sd5));
		send_item(make_load(6, 300, 8, 16'sd3, 16'sd0));
		send_item(make_load(7, 400, 9, -16'sd1, 16'sh7fff));
		send_item(make_tick(65535));
		send_item(make_start(8));
		send_item(make_tick(0));
		send_item(make_tick(5));
		send_item(make_tick(0));
		send_item(make_tick(200));
		send_item(make_tick(1000));
		send_item(make_tick(10));
		// A start with no steps ends on the next tick.
		send_item(make_start(0));
		send_item(make_tick(1));
		send_item(make_start(8));
		send_item(make_tick(65535));
		send_item(make_start(3));
		send_item(make_stop());
		send_item(make_tick(50));
		// A load during playback takes effect immediately.
		send_item(make_start(8));
		send_item(make_tick(0));
		send_item(make_load(2, 50, 7, 16'sd11, -16'sd7));
		send_item(make_tick(50));
		send_item(make_stop());
	endtask

	task automatic test_elapsed_saturation();
		idle_on = 1'b0;
		send_item(make_load(0, 24'hffffff, 6, 16'sd100, 16'sd200));
		send_item(make_start(1));
		while (playing_q)
			send_item(make_tick(65535));
	endtask

	task automatic test_drain_pause();
		int k;
		idle_on = 1'b1;
		send_item(make_load(0, 10, 5, 16'sd5, 16'sd5));
		send_item(make_start(8));
		for (k = 0; k < 3; k++)
			send_item(make_tick(random_advance()));
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		while (playing_q)
			send_item(make_tick(random_advance()));
	endtask

	task automatic play_sequence();
		int n;
		int k;
		int t;
		int r;
		int cnt;
		if ($urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 12);
			t = $urandom_range(0, 50);
			for (k = 0; k < n; k++) begin
				send_item(random_load(k, t));
				t += $urandom_range(0, 300);
			end
		end else begin
			n = $urandom_range(0, 3);
			for (k = 0; k < n; k++)
				send_item(random_load($urandom_range(0, DEPTH - 1), $urandom_range(0, 3000)));
		end
		r = $urandom_range(0, 9);
		if (r == 0)
			cnt = 0;
		else if (r == 1)
			cnt = $urandom_range(DEPTH + 1, 63);
		else
			cnt = $urandom_range(1, DEPTH);
		send_item(make_start(cnt));
		for (k = 0; k < 40 && playing_q; k++) begin
			r = $urandom_range(0, 29);
			if (r == 0)
				send_item(make_stop());
			else if (r < 3)
				send_item(random_load($urandom_range(0, DEPTH - 1), $urandom_range(0, 3000)));
			else
				send_item(make_tick(random_advance()));
		end
	endtask

	task automatic test_random_playback();
		int base;
		int k;
		int t;
		int kind;
		base = items_sent;
		idle_on = 1'b1;
		t = 0;
		for (k = 0; k < DEPTH; k++) begin
			t += $urandom_range(0, 300);
			send_item(random_load(k, t));
		end
		while (items_sent - base < RANDOM_ITEMS) begin
			if (items_sent - base > RANDOM_ITEMS - 30)
				idle_on = 1'b0;
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				play_sequence();
			end else if (kind < 8) begin
				send_item(random_item());
			end else if (kind == 8) begin
				send_item(make_stop());
				send_item(make_tick(random_advance()));
			end else begin
				// Broken sequence: start, disturb the table, tick, then stop early.
				send_item(make_start($urandom_range(0, 63)));
				send_item(random_load($urandom_range(0, DEPTH - 1), $urandom()));
				send_item(make_tick(random_advance()));
				send_item(make_stop());
			end
		end
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		cycles = 0;
		idle_on = 1'b0;
		stall_left = 0;
		n_active = '0;
		next_idx = '0;
		elapsed_ms = '0;
		total_ms = '0;
		playing_q = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_elapsed_saturation();
		test_drain_pause();
		test_random_playback();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("timed_command_sequencer: match");
		else
			$display("timed_command_sequencer: mismatch");
		$finish;
	end

endmodule
